// ===== rtl/block_description_stream_parser_top_defines.svh =====
// Assertion macros for the block description stream parser.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef BLOCK_DESCRIPTION_STREAM_PARSER_TOP_DEFINES_SVH
`define BLOCK_DESCRIPTION_STREAM_PARSER_TOP_DEFINES_SVH

// condition must hold at every sampled edge out of reset
`define BDSP_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define BDSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BDSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bdsp_pkg.sv =====
// Package for the block description stream parser: item types, codes,
// name tables and small helpers. No dependencies.
`timescale 1ns / 1ps

package bdsp_pkg;

  localparam int LINE_BITS = 16;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  field_id;
    logic [7:0]  value_byte;
    logic [3:0]  block_kind;
    logic [2:0]  error_kind;
    logic [15:0] line_number;
    logic        last;
  } out_item_t;

  // one queue entry: all results caused by one item (one or two)
  typedef struct packed {
    logic      two;
    out_item_t res_a;
    out_item_t res_b;
  } q_entry_t;

  typedef enum logic [2:0] {
    PH_OUTSIDE,
    PH_OPEN,
    PH_FIELD,
    PH_VALUE,
    PH_CLOSE
  } phase_e;

  localparam logic [2:0] EV_VALUE     = 3'd0;
  localparam logic [2:0] EV_FIELD_BEG = 3'd1;
  localparam logic [2:0] EV_FIELD_END = 3'd2;
  localparam logic [2:0] EV_DONE      = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;
  localparam logic [2:0] EV_OK        = 3'd5;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_JUNK     = 3'd1;
  localparam logic [2:0] ERR_NO_NL    = 3'd2;
  localparam logic [2:0] ERR_FIELD    = 3'd3;
  localparam logic [2:0] ERR_END      = 3'd4;

  localparam logic [2:0] FLD_TYPE     = 3'd0;
  localparam logic [3:0] KIND_UNKNOWN = 4'd8;

  localparam int NFIELD = 7;
  localparam int NKIND  = 8;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [7:0] FNAME_CHR [NFIELD][8] = '{
    '{"t", "y", "p", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "a", "r", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "a", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "p", "t", "i", "o",   "n",   8'h00, 8'h00},
    '{"i", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "a", "r", "g", "e",   "t",   8'h00, 8'h00}
  };
  localparam logic [2:0] FNAME_LEN [NFIELD] = '{3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd2, 3'd6};

  localparam logic [7:0] KNAME_CHR [NKIND][8] = '{
    '{"c", "o", "l", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"t", "e", "x", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "m", "a", "g", "e", 8'h00, 8'h00, 8'h00},
    '{"s", "c", "r", "i", "p", "t",   8'h00, 8'h00},
    '{"s", "i", "g", "n", "a", "l",   8'h00, 8'h00},
    '{"d", "r", "a", "g", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "f", "o", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "c", "c", "e", "s", "s",   8'h00, 8'h00}
  };
  localparam logic [2:0] KNAME_LEN [NKIND] = '{3'd5, 3'd4, 3'd5, 3'd6, 3'd6, 3'd4, 3'd4, 3'd6};

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SP) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // line count as shown on the result port, clipped to 16 bits
  function automatic logic [15:0] show_line(input logic [LINE_BITS-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    show_line = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic out_item_t mk_res(input logic [2:0] ev, input logic [2:0] fid,
                                       input logic [7:0] vb, input logic [3:0] bk,
                                       input logic [2:0] ek);
    out_item_t r;
    r             = '0;
    r.event_kind  = ev;
    r.field_id    = fid;
    r.value_byte  = vb;
    r.block_kind  = bk;
    r.error_kind  = ek;
    mk_res        = r;
  endfunction

endpackage

// ===== rtl/block_description_stream_parser_top.sv =====
// Top level of the block description stream parser: front end, event
// queue and result back end. Depends on bdsp_pkg and the three submodules.
//
//   channel   handshake        payload      direction
//   input     push / full      in_item_i    into block
//   result    empty / pop      out_item_o   out of block
//
// One input item is taken per cycle while the 4-entry event queue has room;
// the front end finishes each byte in the cycle it is accepted.
// An item makes 0, 1 or 2 results; results leave one per cycle from the output
// register while pop is asserted, so items with two results drain at half rate.
// A result is written to a queue entry and then loaded into the output register.
// Reset (async, active low) returns to outside-block phase, line 1.
`timescale 1ns / 1ps

module block_description_stream_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  bdsp_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output bdsp_pkg::out_item_t out_item_o
);
  import bdsp_pkg::*;

  logic     accept;
  logic     q_wr, q_rd, q_full, q_empty;
  q_entry_t q_wdata, q_rdata;

  assign full   = q_full;
  assign accept = push && !q_full;

  bdsp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .q_wr_o   (q_wr),
    .q_data_o (q_wdata)
  );

  bdsp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  bdsp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/bdsp_front.sv =====
// Front end of the parser: accepts bytes, runs the phase machine and the
// name/kind match masks, and writes the resulting events to the queue.
// Depends on bdsp_pkg.
`timescale 1ns / 1ps

module bdsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  bdsp_pkg::in_item_t item_i,
  output logic              q_wr_o,
  output bdsp_pkg::q_entry_t q_data_o
);
  import bdsp_pkg::*;

  phase_e                phase_q, phase_d;
  logic [NFIELD-1:0]     ncand_q, ncand_d;
  logic [2:0]            npos_q, npos_d;
  logic [2:0]            afield_q, afield_d;
  logic [NKIND-1:0]      kcand_q, kcand_d;
  logic [2:0]            kpos_q, kpos_d;
  logic [3:0]            kcode_q, kcode_d;
  logic [LINE_BITS-1:0]  line_q, line_d;
  logic                  halt_q, halt_d;

  logic [7:0]            c;
  logic [7:0]            lc;
  logic [LINE_BITS-1:0]  line_inc;
  logic [NFIELD-1:0]     nmask;
  logic                  fhit_v;
  logic [2:0]            fhit;
  logic [NKIND-1:0]      kmask;
  logic [3:0]            khit;
  logic [1:0]            nres;
  out_item_t             res_a, res_b;

  assign c  = item_i.byte_in;
  assign lc = ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;

  assign line_inc = (!item_i.at_end && !halt_q && (c == CH_LF) && (line_q != '1))
                    ? line_q + 1'b1 : line_q;

  // field name match: survivors of the next byte, and the first full match
  always_comb begin
    nmask  = '0;
    fhit_v = 1'b0;
    fhit   = '0;
    for (int i = 0; i < NFIELD; i++) begin
      nmask[i] = ncand_q[i] && (npos_q < FNAME_LEN[i]) && (FNAME_CHR[i][npos_q] == c);
    end
    for (int i = NFIELD - 1; i >= 0; i--) begin
      if (ncand_q[i] && (FNAME_LEN[i] == npos_q)) begin
        fhit_v = 1'b1;
        fhit   = 3'(i);
      end
    end
  end

  // block kind match, case-folded
  always_comb begin
    kmask = '0;
    khit  = KIND_UNKNOWN;
    for (int i = 0; i < NKIND; i++) begin
      kmask[i] = kcand_q[i] && (kpos_q < KNAME_LEN[i]) && (KNAME_CHR[i][kpos_q] == lc);
    end
    for (int i = NKIND - 1; i >= 0; i--) begin
      if (kcand_q[i] && (KNAME_LEN[i] == kpos_q)) begin
        khit = 4'(i);
      end
    end
  end

  always_comb begin
    phase_d  = phase_q;
    ncand_d  = ncand_q;
    npos_d   = npos_q;
    afield_d = afield_q;
    kcand_d  = kcand_q;
    kpos_d   = kpos_q;
    kcode_d  = kcode_q;
    line_d   = line_q;
    halt_d   = halt_q;
    nres     = 2'd0;
    res_a    = mk_res(EV_OK, '0, '0, KIND_UNKNOWN, ERR_NONE);
    res_b    = mk_res(EV_OK, '0, '0, KIND_UNKNOWN, ERR_NONE);

    if (accept_i) begin
      if (item_i.at_end) begin
        if (!halt_q) begin
          if (phase_q == PH_CLOSE) begin
            res_a = mk_res(EV_DONE, '0, '0, kcode_q, ERR_NONE);
            nres  = 2'd2;
          end else if (phase_q == PH_OUTSIDE) begin
            nres  = 2'd1;
          end else begin
            res_a = mk_res(EV_ERROR, '0, '0, KIND_UNKNOWN, ERR_END);
            nres  = 2'd1;
          end
        end
        phase_d  = PH_OUTSIDE;
        ncand_d  = '1;
        npos_d   = '0;
        afield_d = '0;
        kcand_d  = '1;
        kpos_d   = '0;
        kcode_d  = KIND_UNKNOWN;
        line_d   = LINE_BITS'(1);
        halt_d   = 1'b0;
      end else if (!halt_q) begin
        line_d = line_inc;
        unique case (phase_q)
          PH_OUTSIDE: begin
            if (c == CH_LBR) begin
              phase_d = PH_OPEN;
            end else if (!is_space(c)) begin
              halt_d = 1'b1;
              res_a  = mk_res(EV_ERROR, '0, '0, KIND_UNKNOWN, ERR_JUNK);
              nres   = 2'd1;
            end
          end
          PH_OPEN: begin
            if ((c == CH_SP) || (c == CH_TAB)) begin
              phase_d = PH_OPEN;
            end else if (c != CH_LF) begin
              halt_d = 1'b1;
              res_a  = mk_res(EV_ERROR, '0, '0, KIND_UNKNOWN, ERR_NO_NL);
              nres   = 2'd1;
            end else begin
              phase_d = PH_FIELD;
              ncand_d = '1;
              npos_d  = '0;
              kcode_d = KIND_UNKNOWN;
              kcand_d = '1;
              kpos_d  = '0;
            end
          end
          PH_FIELD: begin
            if (is_space(c)) begin
              phase_d = PH_FIELD;
            end else if (c == CH_RBR) begin
              phase_d = PH_CLOSE;
            end else if (c == CH_EQ) begin
              if (!fhit_v) begin
                halt_d = 1'b1;
                res_a  = mk_res(EV_ERROR, '0, '0, KIND_UNKNOWN, ERR_FIELD);
              end else begin
                afield_d = fhit;
                phase_d  = PH_VALUE;
                ncand_d  = '1;
                npos_d   = '0;
                if (fhit == FLD_TYPE) begin
                  kcand_d = '1;
                  kpos_d  = '0;
                end
                res_a = mk_res(EV_FIELD_BEG, fhit, '0, KIND_UNKNOWN, ERR_NONE);
              end
              nres = 2'd1;
            end else if (nmask == '0) begin
              halt_d = 1'b1;
              res_a  = mk_res(EV_ERROR, '0, '0, KIND_UNKNOWN, ERR_FIELD);
              nres   = 2'd1;
            end else begin
              ncand_d = nmask;
              if (npos_q != 3'd7) npos_d = npos_q + 3'd1;
            end
          end
          PH_VALUE: begin
            if (c == CH_LF) begin
              if (afield_q == FLD_TYPE) kcode_d = khit;
              res_a   = mk_res(EV_FIELD_END, afield_q, '0, KIND_UNKNOWN, ERR_NONE);
              phase_d = PH_FIELD;
              ncand_d = '1;
              npos_d  = '0;
            end else begin
              if (afield_q == FLD_TYPE) begin
                kcand_d = kmask;
                if (kpos_q != 3'd7) kpos_d = kpos_q + 3'd1;
              end
              res_a = mk_res(EV_VALUE, afield_q, c, KIND_UNKNOWN, ERR_NONE);
            end
            nres = 2'd1;
          end
          PH_CLOSE: begin
            res_a   = mk_res(EV_DONE, '0, '0, kcode_q, ERR_NONE);
            nres    = 2'd1;
            phase_d = PH_OUTSIDE;
          end
          default: begin
            phase_d = PH_OUTSIDE;
          end
        endcase
      end
    end

    res_a.line_number = show_line(line_inc);
    res_b.line_number = show_line(line_inc);
    res_a.last        = (nres == 2'd1);
    res_b.last        = 1'b1;
  end

  assign q_wr_o         = accept_i && (nres != 2'd0);
  assign q_data_o.two   = (nres == 2'd2);
  assign q_data_o.res_a = res_a;
  assign q_data_o.res_b = res_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OUTSIDE;
      ncand_q  <= '1;
      npos_q   <= '0;
      afield_q <= '0;
      kcand_q  <= '1;
      kpos_q   <= '0;
      kcode_q  <= KIND_UNKNOWN;
      line_q   <= LINE_BITS'(1);
      halt_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ncand_q  <= ncand_d;
      npos_q   <= npos_d;
      afield_q <= afield_d;
      kcand_q  <= kcand_d;
      kpos_q   <= kpos_d;
      kcode_q  <= kcode_d;
      line_q   <= line_d;
      halt_q   <= halt_d;
    end
  end

endmodule

// ===== rtl/bdsp_queue.sv =====
// Short queue between parser front and result back end; one entry holds
// the events of one input item. Depends on bdsp_pkg.
`timescale 1ns / 1ps

module bdsp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  bdsp_pkg::q_entry_t wr_data_i,
  input  logic               rd_i,
  output bdsp_pkg::q_entry_t rd_data_o,
  output logic               full_o,
  output logic               empty_o
);
  import bdsp_pkg::*;

  q_entry_t         mem [QDEPTH];
  logic [QAW-1:0]   wp_q, wp_d;
  logic [QAW-1:0]   rp_q, rp_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rd_data_o = mem[rp_q];

  always_comb begin
    wp_d  = do_wr ? QAW'(wp_q + 1'b1) : wp_q;
    rp_d  = do_rd ? QAW'(rp_q + 1'b1) : rp_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/bdsp_back.sv =====
// Back end: unpacks queue entries into single results and holds the
// current result in an output register. Depends on bdsp_pkg.
`timescale 1ns / 1ps

module bdsp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  bdsp_pkg::q_entry_t  q_data_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output bdsp_pkg::out_item_t out_item_o
);
  import bdsp_pkg::*;

  logic      cur_v_q, cur_v_d;
  logic      sec_v_q, sec_v_d;
  out_item_t cur_q, cur_d;
  out_item_t sec_q, sec_d;
  logic      adv;

  // output register frees up when empty or taken this cycle
  assign adv = !cur_v_q || pop_i;

  always_comb begin
    cur_v_d = cur_v_q;
    sec_v_d = sec_v_q;
    cur_d   = cur_q;
    sec_d   = sec_q;
    q_rd_o  = 1'b0;
    if (adv) begin
      if (sec_v_q) begin
        cur_d   = sec_q;
        cur_v_d = 1'b1;
        sec_v_d = 1'b0;
      end else if (!q_empty_i) begin
        q_rd_o  = 1'b1;
        cur_d   = q_data_i.res_a;
        cur_v_d = 1'b1;
        sec_d   = q_data_i.res_b;
        sec_v_d = q_data_i.two;
      end else begin
        cur_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      sec_v_q <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      sec_v_q <= sec_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    sec_q <= sec_d;
  end

  assign empty_o    = !cur_v_q;
  assign out_item_o = cur_q;

endmodule

// ===== rtl/bdsp_checker.sv =====
// Port-level checker for the parser top level, attached by bind.
// Depends on bdsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "block_description_stream_parser_top_defines.svh"

module bdsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input bdsp_pkg::in_item_t  in_item_i,
  input logic                empty,
  input logic                pop,
  input bdsp_pkg::out_item_t out_item_o
);
  import bdsp_pkg::*;

  logic unused_in;
  assign unused_in = push ^ full ^ (^in_item_i);

  `BDSP_ASSERT_NEXT(a_out_hold, (!empty && !pop), (!empty && $stable(out_item_o)), "result changed while stalled")
  `BDSP_ASSERT_HOLDS(a_ev_range, (empty || (out_item_o.event_kind <= EV_OK)), "event kind out of range")
  `BDSP_ASSERT_HOLDS(a_line_nz, (empty || (out_item_o.line_number != 16'd0)), "line number zero")
  `BDSP_ASSERT_IMPL(a_err_only, (!empty && (out_item_o.event_kind != EV_ERROR)), (out_item_o.error_kind == ERR_NONE), "error kind on non-error event")
  `BDSP_ASSERT_IMPL(a_byte_only, (!empty && (out_item_o.event_kind != EV_VALUE)), (out_item_o.value_byte == 8'd0), "value byte on non-value event")

endmodule

bind block_description_stream_parser_top bdsp_checker u_bdsp_checker (.*);
